// ===== sv/kvs_pkg.sv =====
// Shared types and constants for the kernel version scanner.
`timescale 1ns / 1ps

package kvs_pkg;

    localparam int WIN_BYTES     = 14;
    localparam int VALUE_BITS_DEF = 16;
    localparam int OUT_VALUE_BITS = 16;
    localparam int COUNT_BITS    = 4;
    localparam int PARTS         = 3;

    // Patterns are held with their first character in the highest byte, which
    // matches the window layout where the newest byte sits in the lowest byte.
    localparam logic [14*8-1:0] PAT_HEADER    = "Linux version ";
    localparam logic [5*8-1:0]  PAT_ARM64     = "arm64";
    localparam logic [8*8-1:0]  PAT_ARCH_ARM  = "arch/arm";
    localparam logic [9*8-1:0]  PAT_LINUX_ARM = "Linux/arm";

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [1:0] ARCH_NONE  = 2'd0;
    localparam logic [1:0] ARCH_ARM32 = 2'd1;
    localparam logic [1:0] ARCH_ARM64 = 2'd2;

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_SCAN,
        PH_DONE
    } kvs_phase_t;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_A,
        NS_A_DOT,
        NS_B,
        NS_B_DOT,
        NS_C
    } kvs_num_state_t;

    typedef struct packed {
        logic       header_hit;
        logic [1:0] arch_next;
    } kvs_match_t;

endpackage

// ===== sv/kvs_window.sv =====
// Byte window, pattern matching and architecture flags.
`timescale 1ns / 1ps

module kvs_window (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output kvs_pkg::kvs_match_t match
);
    import kvs_pkg::*;

    logic [WIN_BYTES*8-1:0] win_reg;
    logic [WIN_BYTES*8-1:0] win_next;
    logic                   seen_arm64_reg;
    logic                   seen_arm64_next;
    logic                   seen_arm32_reg;
    logic                   seen_arm32_next;
    logic                   hit_arm64;
    logic                   hit_arm32;

    // The window after this byte has been shifted in; the newest byte is lowest.
    assign win_next  = {win_reg[(WIN_BYTES-1)*8-1:0], data_byte};

    assign hit_arm64 = (win_next[5*8-1:0] == PAT_ARM64);
    assign hit_arm32 = (win_next[8*8-1:0] == PAT_ARCH_ARM) ||
                       (win_next[9*8-1:0] == PAT_LINUX_ARM);

    assign seen_arm64_next = seen_arm64_reg | hit_arm64;
    assign seen_arm32_next = seen_arm32_reg | hit_arm32;

    always_comb begin
        match.header_hit = (win_next == PAT_HEADER);
        if (seen_arm64_next) begin
            match.arch_next = ARCH_ARM64;
        end else if (seen_arm32_next) begin
            match.arch_next = ARCH_ARM32;
        end else begin
            match.arch_next = ARCH_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg        <= '0;
            seen_arm64_reg <= 1'b0;
            seen_arm32_reg <= 1'b0;
        end else if (advance) begin
            if (last_byte) begin
                win_reg        <= '0;
                seen_arm64_reg <= 1'b0;
                seen_arm32_reg <= 1'b0;
            end else begin
                win_reg        <= win_next;
                seen_arm64_reg <= seen_arm64_next;
                seen_arm32_reg <= seen_arm32_next;
            end
        end
    end

endmodule

// ===== sv/kvs_number.sv =====
// Header phase control and the digits.digits.digits recogniser.
`timescale 1ns / 1ps

module kvs_number #(
    parameter int VALUE_BITS = kvs_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    input  logic                          header_hit,
    output logic                          found_next,
    output logic [VALUE_BITS-1:0]         val_next [kvs_pkg::PARTS],
    output logic [kvs_pkg::COUNT_BITS-1:0] cnt_next [kvs_pkg::PARTS]
);
    import kvs_pkg::*;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic       clear;
        logic       add_en;
        logic [1:0] part_sel;
        logic       set_found;
    } kvs_num_ctrl_t;

    kvs_phase_t          phase_reg, phase_next;
    kvs_num_state_t      ns_reg, ns_next;
    kvs_num_ctrl_t       ctrl;
    logic                found_reg;
    logic [VALUE_BITS-1:0] val_reg [PARTS];
    logic [COUNT_BITS-1:0] cnt_reg [PARTS];
    logic                is_digit;
    logic                is_dot;
    logic                is_nl;
    logic [3:0]          digit;

    assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign is_dot   = (data_byte == CHAR_DOT);
    assign is_nl    = (data_byte == CHAR_NEWLINE);
    assign digit    = is_digit ? 4'(data_byte - CHAR_ZERO) : 4'd0;

    function automatic logic [VALUE_BITS-1:0] add_digit(input logic [VALUE_BITS-1:0] v,
                                                        input logic [3:0] d);
        logic [VALUE_BITS+3:0] wide;
        begin
            wide = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {{VALUE_BITS{1'b0}}, d};
            add_digit = (wide > {4'd0, VALUE_MAX}) ? VALUE_MAX : wide[VALUE_BITS-1:0];
        end
    endfunction

    // Next state.
    always_comb begin
        phase_next = phase_reg;
        ns_next    = ns_reg;
        unique case (phase_reg)
            PH_SEEK: begin
                if (header_hit) begin
                    phase_next = PH_SCAN;
                    ns_next    = NS_IDLE;
                end
            end
            PH_SCAN: begin
                if (is_nl) begin
                    phase_next = PH_DONE;
                end else begin
                    unique case (ns_reg)
                        NS_IDLE:  ns_next = is_digit ? NS_A : NS_IDLE;
                        NS_A:     ns_next = is_digit ? NS_A : (is_dot ? NS_A_DOT : NS_IDLE);
                        NS_A_DOT: ns_next = is_digit ? NS_B : NS_IDLE;
                        NS_B:     ns_next = is_digit ? NS_B : (is_dot ? NS_B_DOT : NS_IDLE);
                        NS_B_DOT: ns_next = is_digit ? NS_C : NS_IDLE;
                        NS_C: begin
                            if (!is_digit) begin
                                phase_next = PH_DONE;
                            end
                        end
                        default:  ns_next = NS_IDLE;
                    endcase
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Datapath control for the current byte.
    always_comb begin
        ctrl = '0;
        unique case (phase_reg)
            PH_SEEK: begin
                ctrl.clear = header_hit;
            end
            PH_SCAN: begin
                if (!is_nl) begin
                    unique case (ns_reg)
                        NS_IDLE: begin
                            ctrl.clear  = is_digit;
                            ctrl.add_en = is_digit;
                        end
                        NS_A: begin
                            ctrl.add_en = is_digit;
                            ctrl.clear  = !is_digit && !is_dot;
                        end
                        NS_A_DOT: begin
                            ctrl.add_en   = is_digit;
                            ctrl.part_sel = 2'd1;
                            ctrl.clear    = !is_digit;
                        end
                        NS_B: begin
                            ctrl.add_en   = is_digit;
                            ctrl.part_sel = 2'd1;
                            ctrl.clear    = !is_digit && !is_dot;
                        end
                        NS_B_DOT: begin
                            ctrl.add_en    = is_digit;
                            ctrl.part_sel  = 2'd2;
                            ctrl.set_found = is_digit;
                            ctrl.clear     = !is_digit;
                        end
                        NS_C: begin
                            ctrl.add_en   = is_digit;
                            ctrl.part_sel = 2'd2;
                        end
                        default: begin
                            ctrl.clear = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    // A clear comes before the add, so the first digit of a run lands on zero.
    always_comb begin
        found_next = found_reg | ctrl.set_found;
        for (int i = 0; i < PARTS; i++) begin
            val_next[i] = ctrl.clear ? '0 : val_reg[i];
            cnt_next[i] = ctrl.clear ? '0 : cnt_reg[i];
            if (ctrl.add_en && (ctrl.part_sel == 2'(i))) begin
                val_next[i] = add_digit(val_next[i], digit);
                if (cnt_next[i] != COUNT_MAX) begin
                    cnt_next[i] = cnt_next[i] + COUNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEEK;
            ns_reg    <= NS_IDLE;
            found_reg <= 1'b0;
            for (int i = 0; i < PARTS; i++) begin
                val_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else if (advance) begin
            if (last_byte) begin
                phase_reg <= PH_SEEK;
                ns_reg    <= NS_IDLE;
                found_reg <= 1'b0;
                for (int i = 0; i < PARTS; i++) begin
                    val_reg[i] <= '0;
                    cnt_reg[i] <= '0;
                end
            end else begin
                phase_reg <= phase_next;
                ns_reg    <= ns_next;
                found_reg <= found_next;
                for (int i = 0; i < PARTS; i++) begin
                    val_reg[i] <= val_next[i];
                    cnt_reg[i] <= cnt_next[i];
                end
            end
        end
    end

endmodule

// ===== sv/kernel_version_scanner_top.sv =====
// Top level of the kernel version scanner: input stage, scan logic and result register.
`timescale 1ns / 1ps

// Feed the image one byte per transaction on the slave side, with tlast on the
// final byte. Each byte is held in an input register, and the window compares
// and the version recogniser settle between that register and the state
// registers, so a new byte is accepted in every cycle except while the input is
// held back. Only the byte marked last produces a result, which is written to the
// result register as that byte leaves the input register, and the block then
// returns to its reset state ready for the next image. The input is held back
// only while a last byte waits behind an unread result. Version parts saturate
// at 2^VALUE_BITS-1 and are presented as their low 16 bits; digit counts
// saturate at 15. When no version was found all value and count fields are zero.
module kernel_version_scanner_top #(
    parameter int VALUE_BITS = kvs_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] version_found, [16:1] major_value, [20:17] major_digits,
    // [36:21] minor_value, [40:37] minor_digits, [56:41] patch_value,
    // [60:57] patch_digits, [62:61] arch_code, [63] zero
    output logic [63:0] m_tdata
);
    import kvs_pkg::*;

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [63:0]           m_data_reg, m_data_next;
    logic                  advance;
    logic                  out_free;
    kvs_match_t            match;
    logic                  found_next;
    logic [VALUE_BITS-1:0] val_next [PARTS];
    logic [COUNT_BITS-1:0] cnt_next [PARTS];
    logic [OUT_VALUE_BITS-1:0] val_out [PARTS];
    logic [COUNT_BITS-1:0] cnt_out [PARTS];

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    kvs_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .match     (match)
    );

    kvs_number #(
        .VALUE_BITS (VALUE_BITS)
    ) u_number (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .header_hit (match.header_hit),
        .found_next (found_next),
        .val_next   (val_next),
        .cnt_next   (cnt_next)
    );

    always_comb begin
        for (int i = 0; i < PARTS; i++) begin
            val_out[i] = found_next ? OUT_VALUE_BITS'(32'(val_next[i])) : '0;
            cnt_out[i] = found_next ? cnt_next[i] : '0;
        end
        m_data_next = {1'b0, match.arch_next,
                       cnt_out[2], val_out[2],
                       cnt_out[1], val_out[1],
                       cnt_out[0], val_out[0],
                       found_next};
    end

    assign m_valid_next = (advance && in_last_reg) ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A result appears only after a last byte has left the input register.
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg ##1 m_valid_reg |-> $past(advance && in_last_reg))
        else $error("result raised without a last byte");

    // The input stalls only behind a last byte that cannot reach the result register.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && in_last_reg && m_valid_reg && !m_tready)
        else $error("input stalled without cause");

    a_arch_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg[62:61] != 2'd3)
        else $error("invalid architecture code");

    a_empty_when_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg[0] |-> m_data_reg[60:1] == '0)
        else $error("version fields set without a version");

endmodule

// ===== sim/kernel_version_scanner_top_tb.sv =====
// Self-checking testbench for the kernel version scanner: directed images, then random ones.
`timescale 1ns / 1ps

module kernel_version_scanner_top_tb;
    import kvs_pkg::*;

    localparam int          HOLDOFF_CYCLES = 400;
    localparam int unsigned VALUE_MAX      = (1 << VALUE_BITS_DEF) - 1;

    // Laid out as m_tdata, highest bit first.
    typedef struct packed {
        logic        pad;
        logic [1:0]  arch;
        logic [3:0]  patch_digits;
        logic [15:0] patch_value;
        logic [3:0]  minor_digits;
        logic [15:0] minor_value;
        logic [3:0]  major_digits;
        logic [15:0] major_value;
        logic        found;
    } scan_report_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    kernel_version_scanner_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("kernel_version_scanner_top_tb: done, errors");
        $finish;
    end

    // Shadow of the scanner state, updated on every accepted byte.
    logic [WIN_BYTES*8-1:0] recent_bytes;
    kvs_phase_t             line_phase;
    kvs_num_state_t         version_state;
    int unsigned            part_value [PARTS];
    logic [3:0]             part_count [PARTS];
    bit                     version_seen;
    bit                     arm64_seen;
    bit                     arm32_seen;

    scan_report_t reports_due[$];
    scan_report_t typed_report;
    bit           typed_due = 1'b0;

    logic [7:0]   image_bytes[$];
    string        case_text[$];
    bit           case_typed[$];
    scan_report_t case_report[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holdoff_asked = 0;
    int holdoff_taken = 0;
    int hold_left     = 0;
    int bytes_sent    = 0;
    int images_sent   = 0;
    int reports_seen  = 0;
    int versions_seen = 0;
    int arm32_reports = 0;
    int arm64_reports = 0;
    int mismatches    = 0;
    int strays        = 0;

    function automatic scan_report_t make_report(bit found, int unsigned maj, int majd,
                                                 int unsigned mnr, int mnrd,
                                                 int unsigned pat, int patd,
                                                 logic [1:0] arch);
        scan_report_t r;
        r              = '0;
        r.found        = found;
        r.major_value  = 16'(maj);
        r.major_digits = 4'(majd);
        r.minor_value  = 16'(mnr);
        r.minor_digits = 4'(mnrd);
        r.patch_value  = 16'(pat);
        r.patch_digits = 4'(patd);
        r.arch         = arch;
        return r;
    endfunction

    function automatic void drop_parts();
        for (int p = 0; p < PARTS; p++) begin
            part_value[p] = 0;
            part_count[p] = 4'd0;
        end
    endfunction

    function automatic void restart_tracking();
        recent_bytes  = '0;
        line_phase    = PH_SEEK;
        version_state = NS_IDLE;
        version_seen  = 1'b0;
        arm64_seen    = 1'b0;
        arm32_seen    = 1'b0;
        drop_parts();
    endfunction

    function automatic void take_digit(int p, logic [7:0] b);
        int unsigned v;
        v = part_value[p] * 10 + int'(b - CHAR_ZERO);
        part_value[p] = (v > VALUE_MAX) ? VALUE_MAX : v;
        if (part_count[p] != 4'd15)
            part_count[p] = part_count[p] + 4'd1;
    endfunction

    // Advances the shadow state by one accepted byte; a last byte queues its report.
    function automatic void track_byte(logic [7:0] b, bit last);
        bit           is_digit;
        bit           is_dot;
        scan_report_t r;
        is_digit     = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        is_dot       = (b == CHAR_DOT);
        recent_bytes = {recent_bytes[WIN_BYTES*8-9:0], b};
        if (recent_bytes[39:0] == PAT_ARM64)
            arm64_seen = 1'b1;
        if (recent_bytes[63:0] == PAT_ARCH_ARM || recent_bytes[71:0] == PAT_LINUX_ARM)
            arm32_seen = 1'b1;

        if (line_phase == PH_SCAN) begin
            if (b == CHAR_NEWLINE) begin
                line_phase = PH_DONE;
            end else begin
                case (version_state)
                    NS_IDLE: begin
                        if (is_digit) begin
                            drop_parts();
                            take_digit(0, b);
                            version_state = NS_A;
                        end
                    end
                    NS_A: begin
                        if (is_digit) begin
                            take_digit(0, b);
                        end else if (is_dot) begin
                            version_state = NS_A_DOT;
                        end else begin
                            drop_parts();
                            version_state = NS_IDLE;
                        end
                    end
                    NS_A_DOT: begin
                        if (is_digit) begin
                            take_digit(1, b);
                            version_state = NS_B;
                        end else begin
                            drop_parts();
                            version_state = NS_IDLE;
                        end
                    end
                    NS_B: begin
                        if (is_digit) begin
                            take_digit(1, b);
                        end else if (is_dot) begin
                            version_state = NS_B_DOT;
                        end else begin
                            drop_parts();
                            version_state = NS_IDLE;
                        end
                    end
                    NS_B_DOT: begin
                        if (is_digit) begin
                            take_digit(2, b);
                            version_seen  = 1'b1;
                            version_state = NS_C;
                        end else begin
                            drop_parts();
                            version_state = NS_IDLE;
                        end
                    end
                    NS_C: begin
                        if (is_digit)
                            take_digit(2, b);
                        else
                            line_phase = PH_DONE;
                    end
                    default: begin
                        drop_parts();
                        version_state = NS_IDLE;
                    end
                endcase
            end
        end else if (line_phase == PH_SEEK && recent_bytes == PAT_HEADER) begin
            line_phase    = PH_SCAN;
            version_state = NS_IDLE;
            drop_parts();
        end

        if (last) begin
            if (version_seen)
                r = make_report(1'b1, part_value[0], part_count[0], part_value[1],
                                part_count[1], part_value[2], part_count[2], ARCH_NONE);
            else
                r = '0;
            r.arch = arm64_seen ? ARCH_ARM64 : (arm32_seen ? ARCH_ARM32 : ARCH_NONE);
            reports_due.push_back(typed_due ? typed_report : r);
            restart_tracking();
        end
    endfunction

    function automatic string report_diffs(scan_report_t e, scan_report_t g);
        string s;
        s = "";
        if (g.found !== e.found)
            s = {s, $sformatf(" found exp %0d got %0d", e.found, g.found)};
        if (g.major_value !== e.major_value)
            s = {s, $sformatf(" major exp %0d got %0d", e.major_value, g.major_value)};
        if (g.major_digits !== e.major_digits)
            s = {s, $sformatf(" major_digits exp %0d got %0d", e.major_digits, g.major_digits)};
        if (g.minor_value !== e.minor_value)
            s = {s, $sformatf(" minor exp %0d got %0d", e.minor_value, g.minor_value)};
        if (g.minor_digits !== e.minor_digits)
            s = {s, $sformatf(" minor_digits exp %0d got %0d", e.minor_digits, g.minor_digits)};
        if (g.patch_value !== e.patch_value)
            s = {s, $sformatf(" patch exp %0d got %0d", e.patch_value, g.patch_value)};
        if (g.patch_digits !== e.patch_digits)
            s = {s, $sformatf(" patch_digits exp %0d got %0d", e.patch_digits, g.patch_digits)};
        if (g.arch !== e.arch)
            s = {s, $sformatf(" arch exp %0d got %0d", e.arch, g.arch)};
        if (g.pad !== 1'b0)
            s = {s, $sformatf(" spare bit exp 0 got %b", g.pad)};
        return s;
    endfunction

    // Result side: check every transaction, then choose tready for the next cycle.
    always @(posedge aclk) begin
        scan_report_t got;
        scan_report_t want;
        string        diffs;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (reports_due.size() == 0) begin
                strays++;
                if (mismatches + strays <= 10)
                    $display("unexpected result transaction: %h", m_tdata);
            end else begin
                want = reports_due.pop_front();
                reports_seen++;
                if (want.found)
                    versions_seen++;
                if (want.arch == ARCH_ARM32)
                    arm32_reports++;
                if (want.arch == ARCH_ARM64)
                    arm64_reports++;
                diffs = report_diffs(want, got);
                if (diffs != "") begin
                    mismatches++;
                    if (mismatches + strays <= 10)
                        $display("mismatch on result %0d:%s", reports_seen, diffs);
                end
            end
        end
        if (holdoff_asked != holdoff_taken) begin
            holdoff_taken = holdoff_asked;
            hold_left     = HOLDOFF_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        track_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_image();
        for (int i = 0; i < image_bytes.size(); i++)
            send_byte(image_bytes[i], i == image_bytes.size() - 1);
        images_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge aclk);
    endtask

    function automatic void add_text(string t);
        for (int i = 0; i < t.len(); i++)
            image_bytes.push_back(t[i]);
    endfunction

    // Mostly short numbers, now and then long runs that saturate value and count.
    function automatic void add_digits();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(6, 18) : $urandom_range(1, 3);
        repeat (n) image_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void add_case(string t, bit typed, scan_report_t r);
        case_text.push_back(t);
        case_typed.push_back(typed);
        case_report.push_back(r);
    endfunction

    // Most images carry a header and a version with random content; the rest are
    // raw noise, cut-short headers or versions broken by a newline or stray text.
    function automatic void build_image();
        int kind;
        kind = $urandom_range(99);
        image_bytes.delete();
        repeat ($urandom_range(0, 3)) image_bytes.push_back(8'($urandom_range(255)));
        if (kind < 20) begin
            repeat ($urandom_range(1, 6)) image_bytes.push_back(8'($urandom_range(255)));
        end else begin
            case ($urandom_range(5))
                0: add_text("arm64 ");
                1: add_text("arch/arm ");
                2: add_text("Linux/arm ");
                default: ;
            endcase
            if (kind < 28)
                add_text("Linux versio");
            else
                add_text("Linux version ");
            case ($urandom_range(7))
                0: add_text("v");
                1: begin
                    add_digits();
                    add_text(". ");
                end
                2: begin
                    add_digits();
                    add_text(".");
                    add_digits();
                    add_text("-");
                end
                default: ;
            endcase
            add_digits();
            add_text(".");
            add_digits();
            if (kind < 36)
                add_text(".\n");
            else
                add_text(".");
            add_digits();
            case ($urandom_range(6))
                0: add_text("-rc1\n");
                1: add_text(" #1 SMP arm64");
                2: add_text("\nLinux version 9.9.9");
                3: add_text(".7 (Linux/arm)");
                4: add_text(" ");
                default: ;
            endcase
        end
    endfunction

    initial begin
        int base_bytes;
        int errors;
        restart_tracking();

        add_case("x", 1'b1, '0);
        add_case("Linux version 5.10.110\n", 1'b1,
                 make_report(1'b1, 5, 1, 10, 2, 110, 3, ARCH_NONE));
        add_case("Linux version 99999.0.0 arm64", 1'b1,
                 make_report(1'b1, VALUE_MAX, 5, 0, 1, 0, 1, ARCH_ARM64));
        add_case("Linux version 000000000000000000007.01.0x", 1'b1,
                 make_report(1'b1, 7, 15, 1, 2, 0, 1, ARCH_NONE));
        add_case("Linux version 65535.65536.0", 1'b1,
                 make_report(1'b1, VALUE_MAX, 5, VALUE_MAX, 5, 0, 1, ARCH_NONE));
        add_case("Linux version ", 1'b1, '0);
        add_case("Linux version 1.2\n3.4.5", 1'b1, '0);
        add_case("Linux version a\nLinux version 4.4.4", 1'b1, '0);
        add_case("1.2.3", 1'b1, '0);
        add_case("Linux/arm", 1'b1, make_report(1'b0, 0, 0, 0, 0, 0, 0, ARCH_ARM32));
        add_case("Linux/arm64", 1'b1, make_report(1'b0, 0, 0, 0, 0, 0, 0, ARCH_ARM64));
        add_case("arch/arm64", 1'b1, make_report(1'b0, 0, 0, 0, 0, 0, 0, ARCH_ARM64));
        add_case("Linux version 1.2 3.4.5", 1'b0, '0);
        add_case("Linux version 1..2.3.4", 1'b0, '0);
        add_case("Linux version Linux version 7.8.9", 1'b0, '0);
        add_case("arch/arm Linux version 3.18.140-gabc", 1'b0, '0);
        add_case("Linux version 12.34.56 arch/arm", 1'b0, '0);
        add_case("Linux version 2.6.39", 1'b0, '0);
        add_case("\377\200Linux version 6.1.0\177", 1'b0, '0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 25;
        recv_idle_pct = 73;
        for (int c = 0; c < case_text.size(); c++) begin
            image_bytes.delete();
            add_text(case_text[c]);
            typed_due    = case_typed[c];
            typed_report = case_report[c];
            send_image();
            typed_due = 1'b0;
        end
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 25 : ((ph == 1) ? 73 : 0);
            recv_idle_pct = (ph == 0) ? 73 : ((ph == 1) ? 25 : 0);
            if (ph == 2) begin
                // Results pile up behind a stalled receiver until the input is held off.
                holdoff_asked++;
                repeat (2) begin
                    build_image();
                    send_image();
                end
            end
            base_bytes = bytes_sent;
            while (bytes_sent - base_bytes < 20) begin
                build_image();
                send_image();
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        errors = mismatches + strays + reports_due.size();
        $display("covered %0d images in %0d bytes: %0d with a version, %0d arm32, %0d arm64",
                 images_sent, bytes_sent, versions_seen, arm32_reports, arm64_reports);
        $display("%0d results checked, %0d mismatched, %0d unexpected",
                 reports_seen, mismatches, strays);
        if (errors == 0)
            $display("kernel_version_scanner_top_tb: done, clean");
        else
            $display("kernel_version_scanner_top_tb: done, errors");
        $finish;
    end

endmodule

// ===== kernel_version_scanner_top.f =====
sv/kvs_pkg.sv
sv/kvs_window.sv
sv/kvs_number.sv
sv/kernel_version_scanner_top.sv
sim/kernel_version_scanner_top_tb.sv
